[src/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Queue item type, queue sizing, initial hash values and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int QUEUE_DEPTH = 4;

	// One item as it travels from the front end to the back end.
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  cnt;
		logic        last;
	} sha_item_t;

	// Initial hash value for word i.
	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] v;
		case (i)
			3'd0:    v = 32'h6a09e667;
			3'd1:    v = 32'hbb67ae85;
			3'd2:    v = 32'h3c6ef372;
			3'd3:    v = 32'ha54ff53a;
			3'd4:    v = 32'h510e527f;
			3'd5:    v = 32'h9b05688c;
			3'd6:    v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	// Round constant for round r.
	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9aca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

[src/sha_front.sv]
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input items, clamps the byte count and queues them for the back end.
// ----------------------------------------------------------------------------
module sha_front #(
	parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        data_word,
	input  logic [2:0]         valid_bytes,
	input  logic               last_word,
	output logic               q_valid,
	input  logic               q_ready,
	output sha_pkg::sha_item_t q_item
);
	import sha_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sha_item_t          queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	sha_item_t          new_item;
	logic               push, pop;

	// Classify the incoming item: more than four bytes counts as four.
	always_comb begin
		new_item.data = data_word;
		new_item.cnt  = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
		new_item.last = last_word;
	end

	assign in_ready = (fill_q != CNT_W'(QUEUE_DEPTH));
	assign q_valid  = (fill_q != '0);
	assign q_item   = queue_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[src/sha_back.sv]
// ----------------------------------------------------------------------------
// SHA-256 back end
// Packs bytes into the block, pads, runs the rounds and emits the digest.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  sha_pkg::sha_item_t q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               digest_last
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_PEND, S_PAD, S_LEN, S_ROUND, S_FINAL, S_OUT
	} state_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	state_t        state_q;
	logic [511:0]  blk_q;
	logic [31:0]   hash_q [8];
	logic [31:0]   wv_q [8];
	logic [63:0]   len_q;
	logic [5:0]    pos_q;
	logic [5:0]    rnd_q;
	logic [31:0]   pend_word_q;
	logic [2:0]    pend_cnt_q;
	logic          pad_q, len_need_q, done_q;
	logic [2:0]    idx_q;

	logic [31:0]   src_word;
	logic [2:0]    src_cnt;
	logic [511:0]  blk_ins, blk_pad;
	logic [6:0]    pos_sum;
	logic          ovf;
	logic [2:0]    ov_cnt;
	logic [31:0]   ov_word;
	logic [31:0]   w0, w1, w9, w14, w_new;
	logic [31:0]   t1, t2, s1e, s0a, ch, maj;
	logic          take;

	// Byte insertion of a queued or pending item at the current position.
	always_comb begin
		src_word = (state_q == S_PEND) ? pend_word_q : q_item.data;
		src_cnt  = (state_q == S_PEND) ? pend_cnt_q : q_item.cnt;
		blk_ins  = blk_q;
		for (int j = 0; j < 64; j++) begin
			for (int i = 0; i < 4; i++) begin
				if ((3'(i) < src_cnt) && (({1'b0, pos_q} + 7'(i)) == 7'(j))) begin
					blk_ins[511-8*j -: 8] = src_word[31-8*i -: 8];
				end
			end
		end
		pos_sum = {1'b0, pos_q} + {4'd0, src_cnt};
		ovf     = pos_sum[6];
		ov_cnt  = pos_sum[2:0];
		ov_word = src_word << {src_cnt - ov_cnt, 3'b000};
	end

	// Padding: marker byte, zero fill, and the length when it fits.
	always_comb begin
		blk_pad = blk_q;
		for (int j = 0; j < 64; j++) begin
			if (6'(j) == pos_q) begin
				blk_pad[511-8*j -: 8] = 8'h80;
			end else if (6'(j) > pos_q) begin
				blk_pad[511-8*j -: 8] = 8'h00;
			end
		end
		if (pos_q <= 6'd55) begin
			blk_pad[63:0] = len_q;
		end
	end

	// One compression round and the message schedule update.
	always_comb begin
		w0    = blk_q[511:480];
		w1    = blk_q[479:448];
		w9    = blk_q[223:192];
		w14   = blk_q[63:32];
		w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
			+ (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;
		s1e   = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
		ch    = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		t1    = wv_q[7] + s1e + ch + round_k(rnd_q) + w0;
		s0a   = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
		maj   = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t2    = s0a + maj;
	end

	assign q_ready     = (state_q == S_IDLE);
	assign take        = q_valid && q_ready;
	assign out_valid   = (state_q == S_OUT);
	assign digest_word = hash_q[idx_q];
	assign word_index  = idx_q;
	assign digest_last = (idx_q == 3'd7);

	// Block and working variables carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE:  if (take) blk_q <= blk_ins;
			S_PEND:  blk_q <= blk_ins;
			S_PAD:   blk_q <= blk_pad;
			S_LEN:   blk_q <= {448'd0, len_q};
			S_ROUND: blk_q <= {blk_q[479:0], w_new};
			default: blk_q <= blk_q;
		endcase
		if (state_q == S_ROUND) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end else begin
			wv_q <= hash_q;
		end
		if (take && ovf) begin
			pend_word_q <= ov_word;
		end
	end

	// Sequencer and message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
			len_q      <= '0;
			pos_q      <= '0;
			rnd_q      <= '0;
			pend_cnt_q <= '0;
			pad_q      <= 1'b0;
			len_need_q <= 1'b0;
			done_q     <= 1'b0;
			idx_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						len_q <= len_q + {58'd0, q_item.cnt, 3'b000};
						if (ovf) begin
							pend_cnt_q <= ov_cnt;
							pad_q      <= q_item.last;
							pos_q      <= '0;
							rnd_q      <= '0;
							state_q    <= S_ROUND;
						end else begin
							pos_q   <= pos_sum[5:0];
							state_q <= q_item.last ? S_PAD : S_IDLE;
						end
					end
				end
				S_PEND: begin
					pos_q      <= {3'd0, pend_cnt_q};
					pend_cnt_q <= '0;
					pad_q      <= 1'b0;
					state_q    <= pad_q ? S_PAD : S_IDLE;
				end
				S_PAD: begin
					if (pos_q <= 6'd55) begin
						done_q <= 1'b1;
					end else begin
						len_need_q <= 1'b1;
					end
					pos_q   <= '0;
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_LEN: begin
					len_need_q <= 1'b0;
					done_q     <= 1'b1;
					rnd_q      <= '0;
					state_q    <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wv_q[i];
					if (pend_cnt_q != '0) begin
						state_q <= S_PEND;
					end else if (pad_q) begin
						pad_q   <= 1'b0;
						state_q <= S_PAD;
					end else if (len_need_q) begin
						state_q <= S_LEN;
					end else if (done_q) begin
						done_q  <= 1'b0;
						idx_q   <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
							len_q   <= '0;
							pos_q   <= '0;
							idx_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The last digest item hands control back to the idle state.
	a_out_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && digest_last) |=> !out_valid)
		else $error("digest still shown after its last item");

	// Sixty-four rounds are followed by the hash update.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_FINAL))
		else $error("round count did not end in the hash update");

	// A digest is only shown with an empty block buffer.
	a_out_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_q == 6'd0 && pend_cnt_q == 3'd0))
		else $error("digest shown with message bytes outstanding");

endmodule

[src/sha256_message_hash_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hash core
// Hashes a stream of big-endian words and returns the digest as eight items.
// ----------------------------------------------------------------------------
// The back end packs input words while idle and takes no new word while a block
// runs its 64 rounds, one per cycle, and the hash update; the single shared round
// unit limits the steady-state rate. Padding adds one or two blocks; the digest
// follows as eight items, one per cycle while out_ready is high.
// Asynchronous reset loads the initial hash values and empties the queue.
module sha256_message_hash_core #(
	parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	import sha_pkg::*;

	sha_item_t q_item;
	logic      q_valid, q_ready;

	// Front end with its item queue.
	sha_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_word, .valid_bytes, .last_word,
		.q_valid, .q_ready, .q_item
	);

	// Back end with packing, padding, rounds and digest output.
	sha_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid, .out_ready, .digest_word, .word_index, .digest_last
	);

endmodule
